/* src/scfd_pkg.sv */
`default_nettype none

package scfd_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  HeaderReset = 8'd90;
  localparam logic [7:0]  TailReset   = 8'd165;
  localparam logic [15:0] MaxLenReset = 16'd4086;

  // Depth of the queue between the classifying front and the frame engine.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER  = 2'd0,
    CFG_TAIL    = 2'd1,
    CFG_MAX_LEN = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SUM_BAD   = 3'd1,
    ST_TAIL_BAD  = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [7:0]  tail_byte;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_last;
  } in_item_t;

  // A received byte together with its comparisons against the marker bytes.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_last;
    logic       hdr_hit;
    logic       tail_hit;
  } cls_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        is_payload;
    logic        frame_end;
    logic [2:0]  frame_status;
    logic [15:0] sequence_id;
    logic [7:0]  encrypt_code;
    logic [15:0] payload_length;
  } out_item_t;

endpackage

`default_nettype wire

/* src/scfd_if.sv */
`default_nettype none

interface scfd_in_if;
  logic               valid;
  logic               ready;
  scfd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scfd_out_if;
  logic                valid;
  logic                ready;
  scfd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/scfd_front.sv */
`default_nettype none

module scfd_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire scfd_pkg::cfg_t      cfg_i,
  scfd_in_if.sink                  in_chan,
  output logic                     push_o,
  output scfd_pkg::cls_item_t      item_o,
  input  wire logic                full_i
);

  logic                valid_q, valid_d;
  scfd_pkg::cls_item_t item_q, item_d;
  logic                take;

  assign push_o        = valid_q && !full_i;
  assign in_chan.ready = !valid_q || !full_i;
  assign take          = in_chan.valid && in_chan.ready;
  assign item_o        = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d             = 1'b1;
      item_d.rx_byte      = in_chan.data.rx_byte;
      item_d.chunk_last   = in_chan.data.chunk_last;
      item_d.hdr_hit      = (in_chan.data.rx_byte == cfg_i.header_byte);
      item_d.tail_hit     = (in_chan.data.rx_byte == cfg_i.tail_byte);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

`default_nettype wire

/* src/scfd_queue.sv */
`default_nettype none

module scfd_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire scfd_pkg::cls_item_t wdata_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output scfd_pkg::cls_item_t      rdata_o,
  output logic                     empty_o
);

  localparam int unsigned Depth = scfd_pkg::QueueDepth;
  localparam int unsigned PtrW  = scfd_pkg::QueuePtrW;
  localparam int unsigned CntW  = scfd_pkg::QueueCntW;

  scfd_pkg::cls_item_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count beyond its depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("frame engine took a transaction from an empty queue");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue fill count did not follow a lone write");

endmodule

`default_nettype wire

/* src/scfd_back.sv */
`default_nettype none

module scfd_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire scfd_pkg::cfg_t      cfg_i,
  input  wire scfd_pkg::cls_item_t item_i,
  input  wire logic                empty_i,
  output logic                     pop_o,
  scfd_out_if.source               out_chan
);

  typedef enum logic [3:0] {
    PH_HUNT1, PH_HUNT2, PH_ENC, PH_SEQ_HI, PH_SEQ_LO, PH_LEN_HI,
    PH_LEN_LO, PH_PAYLOAD, PH_CHECK, PH_TAIL1, PH_TAIL2
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [15:0]         seq_q, seq_d;
  logic [15:0]         len_q, len_d;
  logic [15:0]         left_q, left_d;
  logic [7:0]          sum_q, sum_d;
  logic [7:0]          enc_q, enc_d;
  logic                mismatch_q, mismatch_d;
  logic                out_valid_q, out_valid_d;
  scfd_pkg::out_item_t out_q, out_d;

  logic                take;
  logic                have, is_pay, fend;
  scfd_pkg::status_e   status;
  logic [7:0]          b;
  logic [7:0]          sum_add;
  logic [15:0]         len_full;

  // The engine moves on whenever the queue holds a byte and the output register is free or being emptied.
  assign take    = !empty_i && (!out_valid_q || out_chan.ready);
  assign pop_o   = take;
  assign b       = item_i.rx_byte;
  assign sum_add = sum_q + b;
  assign len_full = {len_q[15:8], b};

  assign out_chan.valid = out_valid_q;
  assign out_chan.data  = out_q;

  always_comb begin
    phase_d    = phase_q;
    seq_d      = seq_q;
    len_d      = len_q;
    left_d     = left_q;
    sum_d      = sum_q;
    enc_d      = enc_q;
    mismatch_d = mismatch_q;
    have       = 1'b0;
    is_pay     = 1'b0;
    fend       = 1'b0;
    status     = scfd_pkg::ST_OK;

    case (phase_q)
      PH_HUNT1: begin
        if (item_i.hdr_hit) begin
          phase_d = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        if (item_i.hdr_hit) begin
          phase_d    = PH_ENC;
          seq_d      = '0;
          len_d      = '0;
          enc_d      = '0;
          left_d     = '0;
          sum_d      = '0;
          mismatch_d = 1'b0;
        end else begin
          phase_d = PH_HUNT1;
        end
      end
      PH_ENC: begin
        enc_d   = b;
        sum_d   = b;
        phase_d = PH_SEQ_HI;
      end
      PH_SEQ_HI: begin
        seq_d   = {b, 8'd0};
        sum_d   = sum_add;
        phase_d = PH_SEQ_LO;
      end
      PH_SEQ_LO: begin
        seq_d   = {seq_q[15:8], b};
        sum_d   = sum_add;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d   = {b, 8'd0};
        sum_d   = sum_add;
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d = len_full;
        sum_d = sum_add;
        if (len_full > cfg_i.max_length) begin
          have    = 1'b1;
          fend    = 1'b1;
          status  = scfd_pkg::ST_TOO_LONG;
          phase_d = PH_HUNT1;
        end else if (len_full == '0) begin
          phase_d = PH_CHECK;
        end else begin
          left_d  = len_full;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_d  = sum_add;
        have   = 1'b1;
        is_pay = 1'b1;
        left_d = left_q - 16'd1;
        if (left_q == 16'd1) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        mismatch_d = (b != sum_q);
        phase_d    = PH_TAIL1;
      end
      PH_TAIL1: begin
        if (!item_i.tail_hit) begin
          have    = 1'b1;
          fend    = 1'b1;
          status  = scfd_pkg::ST_TAIL_BAD;
          phase_d = PH_HUNT1;
        end else begin
          phase_d = PH_TAIL2;
        end
      end
      PH_TAIL2: begin
        have = 1'b1;
        fend = 1'b1;
        if (!item_i.tail_hit) begin
          status = scfd_pkg::ST_TAIL_BAD;
        end else if (mismatch_q) begin
          status = scfd_pkg::ST_SUM_BAD;
        end else begin
          status = scfd_pkg::ST_OK;
        end
        phase_d = PH_HUNT1;
      end
      default: begin
        phase_d = PH_HUNT1;
      end
    endcase

    // A chunk boundary inside a begun frame cuts it short.
    if (item_i.chunk_last) begin
      if (!fend && (phase_d != PH_HUNT1) && (phase_d != PH_HUNT2)) begin
        have   = 1'b1;
        fend   = 1'b1;
        status = scfd_pkg::ST_TRUNCATED;
      end
      phase_d = PH_HUNT1;
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_chan.ready) begin
      out_valid_d = 1'b0;
    end
    if (take && have) begin
      out_valid_d          = 1'b1;
      out_d.payload_byte   = is_pay ? b : 8'd0;
      out_d.is_payload     = is_pay;
      out_d.frame_end      = fend;
      out_d.frame_status   = fend ? status : scfd_pkg::ST_OK;
      out_d.sequence_id    = seq_d;
      out_d.encrypt_code   = enc_d;
      out_d.payload_length = len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT1;
      seq_q       <= '0;
      len_q       <= '0;
      left_q      <= '0;
      sum_q       <= '0;
      enc_q       <= '0;
      mismatch_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (take) begin
        phase_q    <= phase_d;
        seq_q      <= seq_d;
        len_q      <= len_d;
        left_q     <= left_d;
        sum_q      <= sum_d;
        enc_q      <= enc_d;
        mismatch_q <= mismatch_d;
      end
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  a_end_rehunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && have && fend) |=> phase_q == PH_HUNT1)
    else $error("frame ended but the engine did not return to hunting");

  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.frame_end) |-> out_q.frame_status == scfd_pkg::ST_OK)
    else $error("status reported on a transaction that does not end a frame");

  a_byte_only_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.is_payload) |-> out_q.payload_byte == 8'd0)
    else $error("payload byte set on a transaction without payload");

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> left_q != 16'd0)
    else $error("payload phase with no bytes left to take");

endmodule

`default_nettype wire

/* src/sum_checked_frame_deframer_top.sv */
// Path: a byte accepted lands in the classification register, is written into a queue entry
// and shows its result, if any, in the engine's output register. Throughput: one byte per cycle,
// set by the frame engine taking one queued byte a cycle while its output is not stalled.
// Reset: asynchronous, active low; the marker bytes and length limit return to their
// defaults, the queue empties and the deframer hunts for the first header byte.
`default_nettype none

module sum_checked_frame_deframer_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [scfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [scfd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  scfd_in_if.sink                             in_chan,
  scfd_out_if.source                          out_chan
);

  scfd_pkg::cfg_t      cfg_q;
  scfd_pkg::cls_item_t front_item, queue_item;
  logic                push, full, pop, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte <= scfd_pkg::HeaderReset;
      cfg_q.tail_byte   <= scfd_pkg::TailReset;
      cfg_q.max_length  <= scfd_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      case (scfd_pkg::cfg_idx_e'(cfg_idx_i))
        scfd_pkg::CFG_HEADER:  cfg_q.header_byte <= cfg_wdata_i[7:0];
        scfd_pkg::CFG_TAIL:    cfg_q.tail_byte   <= cfg_wdata_i[7:0];
        scfd_pkg::CFG_MAX_LEN: cfg_q.max_length  <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  scfd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .in_chan (in_chan),
    .push_o  (push),
    .item_o  (front_item),
    .full_i  (full)
  );

  scfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (queue_item),
    .empty_o (empty)
  );

  scfd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (queue_item),
    .empty_i  (empty),
    .pop_o    (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
